// ===== design/pwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_pkg
// shared types and constants for the pulse width capture core
// ----------------------------------------------------------------------------
package pwc_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CMD_W        = 2;
	localparam int CH_W         = 2;
	localparam int CAP_W        = 16;
	localparam int ACC_W        = 32;
	localparam int POL_W        = 4;

	localparam logic [ACC_W-1:0] COUNTER_STEP = ACC_W'(65536);

	localparam logic [CMD_W-1:0] CMD_OVERFLOW = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CAPTURE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [CH_W-1:0]  channel;
		logic [CAP_W-1:0] capture_value;
	} pwc_item_t;

	typedef struct packed {
		logic [ACC_W-1:0] width;
		logic             width_valid;
		logic [POL_W-1:0] edge_polarity;
	} pwc_result_t;

endpackage

// ===== design/pwc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc interfaces
// valid/ready channels for events, results and the polarity register write
// ----------------------------------------------------------------------------
interface pwc_item_if;
	logic                      valid;
	logic                      ready;
	logic [pwc_pkg::CMD_W-1:0] command;
	logic [pwc_pkg::CH_W-1:0]  channel;
	logic [pwc_pkg::CAP_W-1:0] capture_value;

	modport source (output valid, output command, output channel, output capture_value,
		input ready);
	modport sink (input valid, input command, input channel, input capture_value,
		output ready);
endinterface

interface pwc_result_if;
	logic                      valid;
	logic                      ready;
	logic [pwc_pkg::ACC_W-1:0] width;
	logic                      width_valid;
	logic [pwc_pkg::POL_W-1:0] edge_polarity;

	modport source (output valid, output width, output width_valid, output edge_polarity,
		input ready);
	modport sink (input valid, input width, input width_valid, input edge_polarity,
		output ready);
endinterface

interface pwc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [pwc_pkg::POL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/pwc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_engine
// per channel measurement state and the single pass event update
// ----------------------------------------------------------------------------
module pwc_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  pwc_pkg::pwc_item_t        item,
	input  logic [pwc_pkg::POL_W-1:0] idle_polarity,
	output pwc_pkg::pwc_result_t      res
);

	logic [pwc_pkg::NUM_CHANNELS-1:0] meas_q, meas_d;
	logic [pwc_pkg::NUM_CHANNELS-1:0] done_q, done_d;
	logic [pwc_pkg::ACC_W-1:0]        acc_q [pwc_pkg::NUM_CHANNELS];
	logic [pwc_pkg::ACC_W-1:0]        acc_d [pwc_pkg::NUM_CHANNELS];
	logic                             present;

	assign present = (int'(item.channel) < pwc_pkg::NUM_CHANNELS);

	always_comb begin
		meas_d = meas_q;
		done_d = done_q;
		acc_d  = acc_q;
		res    = '0;
		case (item.command)
			pwc_pkg::CMD_OVERFLOW: begin
				for (int c = 0; c < pwc_pkg::NUM_CHANNELS; c++) begin
					acc_d[c] = acc_q[c] + pwc_pkg::COUNTER_STEP;
				end
			end
			pwc_pkg::CMD_CAPTURE: begin
				if (present) begin
					if (!meas_q[item.channel]) begin
						meas_d[item.channel] = 1'b1;
						done_d[item.channel] = 1'b0;
						acc_d[item.channel]  = '0 - pwc_pkg::ACC_W'(item.capture_value);
					end else begin
						meas_d[item.channel] = 1'b0;
						done_d[item.channel] = 1'b1;
						acc_d[item.channel]  = acc_q[item.channel]
							+ pwc_pkg::ACC_W'(item.capture_value);
					end
				end
			end
			pwc_pkg::CMD_READ: begin
				if (present && done_q[item.channel]) begin
					done_d[item.channel] = 1'b0;
					res.width            = acc_q[item.channel];
					res.width_valid      = 1'b1;
				end
			end
			default: begin
			end
		endcase
		for (int c = 0; c < pwc_pkg::POL_W; c++) begin
			if (c < pwc_pkg::NUM_CHANNELS) begin
				res.edge_polarity[c] = idle_polarity[c] ^ meas_d[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q <= '0;
			done_q <= '0;
			for (int c = 0; c < pwc_pkg::NUM_CHANNELS; c++) begin
				acc_q[c] <= '0;
			end
		end else if (fire) begin
			meas_q <= meas_d;
			done_q <= done_d;
			acc_q  <= acc_d;
		end
	end

endmodule

// ===== design/pulse_width_capture_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_capture_core
// four channel pulse width measurement on a 16-bit capture timer
// ----------------------------------------------------------------------------
// the item is registered in the input stage and its result in the result stage
// throughput: one item per cycle unless the result side stalls, set by the single pass state update
// the output register holds a stalled result while the next item waits in the input stage
// reset: asynchronous, clears polarity, measuring, done flags and accumulators
// ----------------------------------------------------------------------------
module pulse_width_capture_core (
	input  logic         clk,
	input  logic         arst_n,
	pwc_item_if.sink     item,
	pwc_result_if.source result,
	pwc_cfg_if.sink      cfg
);

	logic                      item_valid_s1;
	pwc_pkg::pwc_item_t        item_s1;
	logic                      res_valid_q;
	pwc_pkg::pwc_result_t      res_q;
	pwc_pkg::pwc_result_t      res_d;
	logic [pwc_pkg::POL_W-1:0] idle_pol_q;
	logic                      fire;

	assign fire       = item_valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !item_valid_s1 || fire;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_pol_q <= '0;
		end else if (cfg.valid) begin
			idle_pol_q <= cfg.data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.command       <= item.command;
			item_s1.channel       <= item.channel;
			item_s1.capture_value <= item.capture_value;
		end
	end

	pwc_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.idle_polarity (idle_pol_q),
		.res           (res_d)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.width         = res_q.width;
	assign result.width_valid   = res_q.width_valid;
	assign result.edge_polarity = res_q.edge_polarity;

endmodule

// ===== test/pulse_width_capture_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_capture_core_tb
// drives overflow, capture, read and unused command events into the core with random gaps
// on both sides, tracks measuring state, accumulators, done flags and the
// idle polarity alongside it, and compares every result beat field by field
// ----------------------------------------------------------------------------
module pulse_width_capture_core_tb;
	import pwc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_EVENTS = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;

	pwc_item_if   item_bus ();
	pwc_result_if result_bus ();
	pwc_cfg_if    cfg_bus ();

	assign result_bus.ready = sink_ready;

	pulse_width_capture_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus.sink),
		.result (result_bus.source),
		.cfg    (cfg_bus.sink)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [POL_W-1:0]        idle_pol;
	logic [NUM_CHANNELS-1:0] busy_mask;
	logic [NUM_CHANNELS-1:0] done_mask;
	logic [ACC_W-1:0]        span_acc [NUM_CHANNELS];
	pwc_result_t             awaited_results [$];

	bit src_quiet;
	bit sink_quiet;
	int unsigned sink_hold;
	int unsigned cycle_count;
	int unsigned fail_count;
	int unsigned events_sent;
	int unsigned beats_checked;
	int unsigned widths_read;
	int unsigned polarity_writes;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pwc_result_t measure_event(pwc_item_t ev);
		pwc_result_t res;
		res = '0;
		case (ev.command)
			CMD_OVERFLOW: begin
				for (int c = 0; c < NUM_CHANNELS; c++)
					span_acc[c] = span_acc[c] + COUNTER_STEP;
			end
			CMD_CAPTURE: begin
				if (!busy_mask[ev.channel]) begin
					busy_mask[ev.channel] = 1'b1;
					span_acc[ev.channel] = ACC_W'(0) - ACC_W'(ev.capture_value);
					done_mask[ev.channel] = 1'b0;
				end else begin
					busy_mask[ev.channel] = 1'b0;
					span_acc[ev.channel] = span_acc[ev.channel] + ACC_W'(ev.capture_value);
					done_mask[ev.channel] = 1'b1;
				end
			end
			CMD_READ: begin
				if (done_mask[ev.channel]) begin
					done_mask[ev.channel] = 1'b0;
					res.width = span_acc[ev.channel];
					res.width_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.edge_polarity = idle_pol ^ busy_mask;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// one event beat, entered and left at a falling edge
	task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
		input logic [CAP_W-1:0] cap);
		pwc_item_t ev;
		int unsigned gap;
		gap = src_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			item_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		ev.command = cmd;
		ev.channel = ch;
		ev.capture_value = cap;
		item_bus.valid = 1'b1;
		item_bus.command = cmd;
		item_bus.channel = ch;
		item_bus.capture_value = cap;
		do
			@(posedge clk);
		while (!item_bus.ready);
		awaited_results.push_back(measure_event(ev));
		events_sent++;
		@(negedge clk);
	endtask

	// hold off until every result beat is back
	task automatic settle();
		item_bus.valid = 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_polarity(input logic [POL_W-1:0] pol);
		cfg_bus.valid = 1'b1;
		cfg_bus.data = pol;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		idle_pol = pol;
		polarity_writes++;
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic test_basic_measure();
		send_event(CMD_READ, 2'd0, 16'h0000);
		send_event(CMD_CAPTURE, 2'd0, 16'h0000);
		send_event(CMD_OVERFLOW, 2'd2, 16'h5a5a);
		send_event(CMD_OVERFLOW, 2'd1, 16'ha5a5);
		send_event(CMD_CAPTURE, 2'd0, 16'hffff);
		send_event(CMD_READ, 2'd0, 16'hffff);
		send_event(CMD_READ, 2'd0, 16'h0000);
		send_event(CMD_UNUSED, 2'd3, 16'hffff);
		send_event(CMD_CAPTURE, 2'd3, 16'hffff);
		send_event(CMD_CAPTURE, 2'd3, 16'h0000);
		send_event(CMD_READ, 2'd3, 16'h0000);
		send_event(CMD_CAPTURE, 2'd1, 16'h1234);
		send_event(CMD_OVERFLOW, 2'd0, 16'h0000);
		send_event(CMD_CAPTURE, 2'd1, 16'habcd);
		send_event(CMD_CAPTURE, 2'd1, 16'h0000);
		send_event(CMD_READ, 2'd1, 16'h0000);
		settle();
	endtask

	// polarity changes while channel 1, then channel 2, then channel 3 is still measuring
	task automatic test_polarity_change();
		write_polarity(4'hf);
		send_event(CMD_CAPTURE, 2'd1, 16'h00ff);
		send_event(CMD_READ, 2'd1, 16'h0000);
		send_event(CMD_CAPTURE, 2'd2, 16'h8000);
		settle();
		write_polarity(4'h0);
		send_event(CMD_CAPTURE, 2'd2, 16'h7fff);
		send_event(CMD_READ, 2'd2, 16'h0000);
		settle();
		write_polarity(4'h5);
		send_event(CMD_CAPTURE, 2'd3, 16'h0001);
		settle();
		write_polarity(4'ha);
		send_event(CMD_READ, 2'd3, 16'h0000);
		settle();
	endtask

	task automatic random_event(output bit counted);
		int unsigned r;
		int unsigned s;
		logic [CMD_W-1:0] cmd;
		logic [CAP_W-1:0] cap;
		r = $urandom_range(0, 99);
		if (r < 25)
			cmd = CMD_OVERFLOW;
		else if (r < 65)
			cmd = CMD_CAPTURE;
		else if (r < 95)
			cmd = CMD_READ;
		else
			cmd = CMD_UNUSED;
		s = $urandom_range(0, 9);
		if (s == 0)
			cap = 16'h0000;
		else if (s == 1)
			cap = 16'hffff;
		else
			cap = CAP_W'($urandom_range(0, 65535));
		send_event(cmd, CH_W'($urandom_range(0, NUM_CHANNELS - 1)), cap);
		counted = (cmd != CMD_UNUSED);
	endtask

	task automatic test_random_traffic();
		int unsigned done_events;
		bit counted;
		logic [POL_W-1:0] pol;
		for (int k = 0; k < RANDOM_PHASES; k++) begin
			if (k == 0)
				pol = 4'hf;
			else if (k == 1)
				pol = 4'h0;
			else
				pol = POL_W'($urandom_range(0, 15));
			write_polarity(pol);
			src_quiet = (k == 3);
			sink_quiet = (k == 3) || (k == 5);
			done_events = 0;
			while (done_events < PHASE_EVENTS) begin
				random_event(counted);
				if (counted)
					done_events++;
			end
			settle();
		end
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
	endtask

	always @(negedge clk) begin
		if (sink_hold != 0) begin
			sink_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			sink_ready <= 1'b1;
			sink_hold <= sink_quiet ? 0 : pick_gap();
		end
	end

	always @(posedge clk) begin
		pwc_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result beat", result_bus.width, 32'd0);
			end else begin
				want = awaited_results.pop_front();
				beats_checked++;
				if (result_bus.width_valid)
					widths_read++;
				if (result_bus.width !== want.width)
					report_mismatch("width", result_bus.width, want.width);
				if (result_bus.width_valid !== want.width_valid)
					report_mismatch("width_valid", 32'(result_bus.width_valid),
						32'(want.width_valid));
				if (result_bus.edge_polarity !== want.edge_polarity)
					report_mismatch("edge_polarity", 32'(result_bus.edge_polarity),
						32'(want.edge_polarity));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				awaited_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		item_bus.valid = 1'b0;
		item_bus.command = CMD_OVERFLOW;
		item_bus.channel = '0;
		item_bus.capture_value = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		idle_pol = '0;
		busy_mask = '0;
		done_mask = '0;
		for (int c = 0; c < NUM_CHANNELS; c++)
			span_acc[c] = '0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		sink_hold = 0;
		cycle_count = 0;
		fail_count = 0;
		events_sent = 0;
		beats_checked = 0;
		widths_read = 0;
		polarity_writes = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_measure();
		test_polarity_change();
		test_random_traffic();

		settle();
		repeat (8) @(negedge clk);
		$display("sent %0d events, checked %0d result beats, %0d finished widths read",
			events_sent, beats_checked, widths_read);
		$display("%0d polarity writes, %0d mismatches", polarity_writes, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/pwc_pkg.sv
design/pwc_if.sv
design/pwc_engine.sv
design/pulse_width_capture_core.sv
test/pulse_width_capture_core_tb.sv
